### sv/gpr_pkg.sv
// Package for the grid path reachability block.
// Holds cell codes, direction and controller state types, and reset constants.
// No dependencies.
package gpr_pkg;

    localparam logic [1:0] CODE_WALL   = 2'd0;
    localparam logic [1:0] CODE_SOURCE = 2'd1;
    localparam logic [1:0] CODE_DEST   = 2'd2;
    localparam logic [1:0] CODE_OPEN   = 2'd3;

    localparam int         SIDE_BITS  = 5;
    localparam logic [4:0] SIDE_RESET = 5'd16;

    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_UP,
        DIR_LEFT
    } gpr_dir_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_POP,
        ST_QWAIT,
        ST_NB_RD,
        ST_NB_CHK,
        ST_FINISH
    } gpr_state_t;

endpackage

### sv/gpr_if.sv
// Valid/ready channel interfaces for the grid path reachability block.
// Depends on nothing; one interface for cells in, one for the result out.
interface gpr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cell_code;
    logic       last_cell;
    modport source (output valid, output cell_code, output last_cell, input ready);
    modport sink (input valid, input cell_code, input last_cell, output ready);
endinterface

interface gpr_out_if;
    logic valid;
    logic ready;
    logic path_found;
    modport source (output valid, output path_found, input ready);
    modport sink (input valid, input path_found, output ready);
endinterface

### sv/gpr_cell_mem.sv
// Cell memory: per cell a visited flag above the 2-bit cell code.
// Synchronous, one write and one read port, registered read data.
module gpr_cell_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 3
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/gpr_queue_mem.sv
// Search queue memory: row and column of each queued cell.
// Synchronous, one write and one read port, registered read data.
module gpr_queue_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/grid_path_reachability.sv
// Top level of the grid path reachability block: controller plus two memories.
// Depends on gpr_pkg, gpr_if, gpr_cell_mem and gpr_queue_mem.
//
// Cells are taken one per cycle in row-major order while the block is in its
// load state. After the cell marked last, the block scans the loaded cells for
// sources (a read step and a check step per loaded cell), then runs a
// breadth-first search in which each dequeued cell takes a pop and a queue wait
// step plus a read and a check step for each of its in-grid neighbours, as the
// cell memory has a single read port. The search ends early when a destination
// is reached; one result transfer follows.
// No new cells are taken while a search runs. Loading a cell also clears its
// visited flag, so no clearing pass is needed.
module grid_path_reachability
    import gpr_pkg::*;
#(
    parameter int MAX_SIDE = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [SIDE_BITS-1:0] cfg_data,
    gpr_in_if.sink               cells,
    gpr_out_if.source            result
);

    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int IW    = $clog2(CELLS);
    localparam int RW    = $clog2(MAX_SIDE);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int QW    = 2 * RW;

    gpr_state_t           state_reg, state_next;
    gpr_dir_t             dir_reg, dir_next;
    logic [SIDE_BITS-1:0] side_length_reg;
    logic [SW-1:0]        side_reg, side_next, side_cur;
    logic [CW-1:0]        load_count_reg, load_count_next, total_cur;
    logic [CW-1:0]        filled_reg, filled_next;
    logic [CW-1:0]        head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0]        scan_idx_reg, scan_idx_next;
    logic [RW-1:0]        scan_row_reg, scan_row_next, scan_col_reg, scan_col_next;
    logic [RW-1:0]        cur_row_reg, cur_row_next, cur_col_reg, cur_col_next;
    logic [RW-1:0]        nr_reg, nr_next, nc_reg, nc_next;
    logic [IW-1:0]        nidx_reg, nidx_next;
    logic                 found_reg, found_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 path_reg, path_next;

    logic                 store_cell;
    logic                 nb_ok;
    logic [RW-1:0]        nb_row, nb_col;
    logic [CW-1:0]        nb_idx_full;
    logic                 nb_live;
    logic [1:0]           nb_code;

    logic                 cell_we;
    logic [IW-1:0]        cell_waddr, cell_raddr;
    logic [2:0]           cell_wdata, cell_rdata;
    logic                 q_we;
    logic [QW-1:0]        q_wdata, q_rdata;

    gpr_cell_mem #(
        .DEPTH (CELLS),
        .WIDTH (3)
    ) u_cell_mem (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    gpr_queue_mem #(
        .DEPTH (CELLS),
        .WIDTH (QW)
    ) u_queue_mem (
        .clk   (clk),
        .we    (q_we),
        .waddr (tail_reg[IW-1:0]),
        .wdata (q_wdata),
        .raddr (head_reg[IW-1:0]),
        .rdata (q_rdata)
    );

    // Side in force: zero counts as one, anything above the maximum is clamped.
    always_comb
    begin
        if (side_length_reg == '0)
        begin
            side_cur = SW'(1);
        end
        else if (int'(side_length_reg) > MAX_SIDE)
        begin
            side_cur = SW'(MAX_SIDE);
        end
        else
        begin
            side_cur = SW'(side_length_reg);
        end
    end

    assign total_cur  = CW'(side_cur) * CW'(side_cur);
    assign store_cell = load_count_reg < total_cur;

    // Neighbour of the current cell in the present direction.
    always_comb
    begin
        nb_row = cur_row_reg;
        nb_col = cur_col_reg;
        nb_ok  = 1'b0;
        unique case (dir_reg)
            DIR_RIGHT:
            begin
                nb_ok  = (SW'(cur_col_reg) + SW'(1)) < side_reg;
                nb_col = cur_col_reg + RW'(1);
            end
            DIR_DOWN:
            begin
                nb_ok  = (SW'(cur_row_reg) + SW'(1)) < side_reg;
                nb_row = cur_row_reg + RW'(1);
            end
            DIR_UP:
            begin
                nb_ok  = cur_row_reg != '0;
                nb_row = cur_row_reg - RW'(1);
            end
            DIR_LEFT:
            begin
                nb_ok  = cur_col_reg != '0;
                nb_col = cur_col_reg - RW'(1);
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

    assign nb_idx_full = CW'(nb_row) * CW'(side_reg) + CW'(nb_col);

    // Cells past the loaded count read as walls; visited cells are skipped.
    assign nb_live = (CW'(nidx_reg) < filled_reg) && !cell_rdata[2];
    assign nb_code = cell_rdata[1:0];

    assign cell_raddr = (state_reg == ST_NB_RD) ? nb_idx_full[IW-1:0]
                                                : scan_idx_reg[IW-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (cells.valid && cells.last_cell)
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = (scan_idx_reg == filled_reg) ? ST_POP : ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                state_next = ST_SCAN_RD;
            end
            ST_POP:
            begin
                state_next = (head_reg == tail_reg) ? ST_FINISH : ST_QWAIT;
            end
            ST_QWAIT:
            begin
                state_next = ST_NB_RD;
            end
            ST_NB_RD:
            begin
                if (nb_ok)
                begin
                    state_next = ST_NB_CHK;
                end
                else if (dir_reg == DIR_LEFT)
                begin
                    state_next = ST_POP;
                end
            end
            ST_NB_CHK:
            begin
                if (nb_live && nb_code == CODE_DEST)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = (dir_reg == DIR_LEFT) ? ST_POP : ST_NB_RD;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        dir_next        = dir_reg;
        side_next       = side_reg;
        load_count_next = load_count_reg;
        filled_next     = filled_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        scan_idx_next   = scan_idx_reg;
        scan_row_next   = scan_row_reg;
        scan_col_next   = scan_col_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        nr_next         = nr_reg;
        nc_next         = nc_reg;
        nidx_next       = nidx_reg;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        path_next       = path_reg;
        cell_we         = 1'b0;
        cell_waddr      = load_count_reg[IW-1:0];
        cell_wdata      = {1'b0, cells.cell_code};
        q_we            = 1'b0;
        q_wdata         = {scan_row_reg, scan_col_reg};
        unique case (state_reg)
            ST_LOAD:
            begin
                if (cells.valid)
                begin
                    cell_we = store_cell;
                    if (cells.last_cell)
                    begin
                        // A shrunken side can leave more cells loaded than it covers.
                        filled_next     = store_cell ? load_count_reg + CW'(1)
                                                     : total_cur;
                        load_count_next = '0;
                        side_next       = side_cur;
                        head_next       = '0;
                        tail_next       = '0;
                        scan_idx_next   = '0;
                        scan_row_next   = '0;
                        scan_col_next   = '0;
                        found_next      = 1'b0;
                    end
                    else if (store_cell)
                    begin
                        load_count_next = load_count_reg + CW'(1);
                    end
                end
            end
            ST_SCAN_RD:
            begin
            end
            ST_SCAN_CHK:
            begin
                if (cell_rdata[1:0] == CODE_SOURCE)
                begin
                    cell_we    = 1'b1;
                    cell_waddr = scan_idx_reg[IW-1:0];
                    cell_wdata = {1'b1, CODE_SOURCE};
                    q_we       = 1'b1;
                    tail_next  = tail_reg + CW'(1);
                end
                scan_idx_next = scan_idx_reg + CW'(1);
                if ((SW'(scan_col_reg) + SW'(1)) == side_reg)
                begin
                    scan_col_next = '0;
                    scan_row_next = scan_row_reg + RW'(1);
                end
                else
                begin
                    scan_col_next = scan_col_reg + RW'(1);
                end
            end
            ST_POP:
            begin
                if (head_reg != tail_reg)
                begin
                    head_next = head_reg + CW'(1);
                end
            end
            ST_QWAIT:
            begin
                cur_row_next = q_rdata[QW-1:RW];
                cur_col_next = q_rdata[RW-1:0];
                dir_next     = DIR_RIGHT;
            end
            ST_NB_RD:
            begin
                if (nb_ok)
                begin
                    nidx_next = nb_idx_full[IW-1:0];
                    nr_next   = nb_row;
                    nc_next   = nb_col;
                end
                else if (dir_reg != DIR_LEFT)
                begin
                    dir_next = gpr_dir_t'(dir_reg + 2'd1);
                end
            end
            ST_NB_CHK:
            begin
                if (nb_live && nb_code == CODE_DEST)
                begin
                    found_next = 1'b1;
                end
                else
                begin
                    if (nb_live && nb_code == CODE_OPEN)
                    begin
                        cell_we    = 1'b1;
                        cell_waddr = nidx_reg;
                        cell_wdata = {1'b1, CODE_OPEN};
                        q_we       = 1'b1;
                        q_wdata    = {nr_reg, nc_reg};
                        tail_next  = tail_reg + CW'(1);
                    end
                    if (dir_reg != DIR_LEFT)
                    begin
                        dir_next = gpr_dir_t'(dir_reg + 2'd1);
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    path_next      = found_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            side_length_reg <= SIDE_RESET;
            load_count_reg  <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                side_length_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg      <= dir_next;
        side_reg     <= side_next;
        filled_reg   <= filled_next;
        scan_idx_reg <= scan_idx_next;
        scan_row_reg <= scan_row_next;
        scan_col_reg <= scan_col_next;
        cur_row_reg  <= cur_row_next;
        cur_col_reg  <= cur_col_next;
        nr_reg       <= nr_next;
        nc_reg       <= nc_next;
        nidx_reg     <= nidx_next;
        found_reg    <= found_next;
        path_reg     <= path_next;
    end

    assign cells.ready       = state_reg == ST_LOAD;
    assign result.valid      = out_valid_reg;
    assign result.path_found = path_reg;

    // The queue is never read beyond what was written in this search.
    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed the tail");

    // A result only appears on leaving the finishing state.
    a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finishing state");

    // Loading never counts past the largest grid.
    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(load_count_reg) <= CELLS)
        else $error("load count beyond grid capacity");

    // A cell marked last always starts the source scan.
    a_last_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cells.valid && cells.ready && cells.last_cell) |=> state_reg == ST_SCAN_RD)
        else $error("last cell did not start the search");

endmodule

### dv/gpr_tb_if.sv
`timescale 1ns / 1ps
// Testbench copy point for the channel interfaces: none needed beyond the RTL's own.
// The block's interfaces live in sv/gpr_if.sv; this file only holds test helpers.
// Depends on gpr_pkg.
package gpr_tb_pkg;
    import gpr_pkg::*;

    localparam int TB_MAX_SIDE = 16;

    // One cell transfer as the testbench holds it.
    typedef struct packed {
        logic [1:0] code;
        logic       last;
    } cell_item_t;
endpackage

### dv/grid_path_reachability_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for grid_path_reachability: loads grids, predicts reachability.
// Depends on gpr_pkg, gpr_if, gpr_tb_pkg and the RTL.
module grid_path_reachability_tb;
    import gpr_pkg::*;
    import gpr_tb_pkg::*;

    localparam int CELLS = TB_MAX_SIDE * TB_MAX_SIDE;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int TAIL_CYCLES = 3200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [SIDE_BITS-1:0] cfg_data = '0;

    gpr_in_if cells_ch();
    gpr_out_if result_ch();

    grid_path_reachability #(.MAX_SIDE(TB_MAX_SIDE)) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .cells(cells_ch.sink),
        .result(result_ch.source)
    );

    always #4 clk = ~clk;

    // Predictor state.
    logic [1:0] grid_codes [CELLS];
    int unsigned cells_loaded;
    logic [4:0] side_reg;
    logic expected_found_q [$];
    // Typed-in expectation of the row being sent (-1 when left to the predictor).
    int typed_next = -1;
    int typed_q [$];

    int mismatches = 0;
    int idle_cycles = 0;
    bit timed_out = 1'b0;
    bit quiet_mode = 1'b0;
    bit done_sending = 1'b0;

    function automatic int unsigned side_now();
        if (side_reg == 0) return 1;
        if (side_reg > TB_MAX_SIDE) return TB_MAX_SIDE;
        return side_reg;
    endfunction

    // Breadth-first search from all sources at once over the loaded cells.
    function automatic logic search_reaches_dest();
        int unsigned side;
        int unsigned filled;
        bit seen [CELLS];
        int fifo [$];
        int cur;
        int r;
        int c;
        int nr;
        int nc;
        int nidx;
        int drow [4];
        int dcol [4];
        logic [1:0] code;
        side = side_now();
        filled = (cells_loaded < side * side) ? cells_loaded : side * side;
        drow = '{0, 1, -1, 0};
        dcol = '{1, 0, 0, -1};
        foreach (seen[i]) seen[i] = 1'b0;
        for (int i = 0; i < filled; i++)
        begin
            if (grid_codes[i] == CODE_SOURCE)
            begin
                seen[i] = 1'b1;
                fifo.push_back(i);
            end
        end
        while (fifo.size() > 0)
        begin
            cur = fifo.pop_front();
            r = cur / side;
            c = cur % side;
            for (int k = 0; k < 4; k++)
            begin
                nr = r + drow[k];
                nc = c + dcol[k];
                if (nr < 0 || nc < 0 || nr >= side || nc >= side) continue;
                nidx = nr * side + nc;
                if (seen[nidx]) continue;
                code = (nidx < filled) ? grid_codes[nidx] : CODE_WALL;
                if (code == CODE_DEST) return 1'b1;
                if (code != CODE_OPEN) continue;
                seen[nidx] = 1'b1;
                fifo.push_back(nidx);
            end
        end
        return 1'b0;
    endfunction

    // Called for each accepted cell transfer.
    function automatic void absorb_cell(logic [1:0] code, logic last);
        int unsigned side;
        side = side_now();
        if (cells_loaded < side * side)
        begin
            grid_codes[cells_loaded] = code;
            cells_loaded++;
        end
        if (last)
        begin
            expected_found_q.push_back(search_reaches_dest());
            typed_q.push_back(typed_next);
            typed_next = -1;
            cells_loaded = 0;
        end
    endfunction

    task automatic note_mismatch(string what, logic exp_v, logic act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0b actual %0b at %0t", what, exp_v, act_v, $time);
    endtask

    // Monitor on the cell channel.
    always @(posedge clk)
    begin
        if (rst_n && cells_ch.valid && cells_ch.ready)
            absorb_cell(cells_ch.cell_code, cells_ch.last_cell);
    end

    // Result checker.
    always @(posedge clk)
    begin
        logic exp_v;
        int typed;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_found_q.size() == 0)
                note_mismatch("unexpected result", 1'bx, result_ch.path_found);
            else
            begin
                exp_v = expected_found_q.pop_front();
                typed = typed_q.pop_front();
                if (result_ch.path_found !== exp_v)
                    note_mismatch("path_found", exp_v, result_ch.path_found);
                if (typed >= 0 && result_ch.path_found !== typed[0])
                    note_mismatch("typed path_found", typed[0], result_ch.path_found);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((cells_ch.valid && cells_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver with random stall bursts.
    initial
    begin
        int stall;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet_mode && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 7);
                result_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Sends one cell and waits for its transfer; idles at random before it.
    task automatic send_cell(logic [1:0] code, logic last);
        int gap;
        if (!quiet_mode && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 7);
            cells_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cells_ch.valid <= 1'b1;
        cells_ch.cell_code <= code;
        cells_ch.last_cell <= last;
        @(posedge clk);
        while (!cells_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_and_idle();
        cells_ch.valid <= 1'b0;
        while (expected_found_q.size() > 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_side(logic [4:0] value);
        drain_and_idle();
        cfg_we <= 1'b1;
        cfg_data <= value;
        side_reg = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random grid: mostly open cells with a few sources and destinations.
    task automatic send_grid(int unsigned n_cells, int wall_pct);
        logic [1:0] code;
        int roll;
        for (int i = 0; i < n_cells; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < wall_pct) code = CODE_WALL;
            else if (roll < wall_pct + 4) code = CODE_SOURCE;
            else if (roll < wall_pct + 8) code = CODE_DEST;
            else code = CODE_OPEN;
            send_cell(code, i == n_cells - 1);
        end
    endtask

    typedef struct {
        logic [1:0] code;
        logic       last;
        int         found;   // -1 when left to the predictor
    } directed_row_t;

    initial
    begin
        directed_row_t rows [$];
        int unsigned side;
        int unsigned n;
        int unsigned items;

        cells_ch.valid = 1'b0;
        cells_ch.cell_code = CODE_WALL;
        cells_ch.last_cell = 1'b0;
        side_reg = SIDE_RESET;
        cells_loaded = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Side 1: a lone cell can never reach anything.
        write_side(5'd1);
        rows = '{
            '{CODE_SOURCE, 1'b1, 0},
            '{CODE_DEST,   1'b1, 0},
            '{CODE_WALL,   1'b0, -1},
            '{CODE_OPEN,   1'b1, 0}
        };
        foreach (rows[i])
        begin
            typed_next = rows[i].found;
            send_cell(rows[i].code, rows[i].last);
        end

        // Side 2: adjacent source and destination, blocked diagonal, extra cells ignored.
        write_side(5'd2);
        rows = '{
            '{CODE_SOURCE, 1'b0, -1}, '{CODE_DEST, 1'b0, -1},
            '{CODE_WALL,   1'b0, -1}, '{CODE_WALL, 1'b1, 1},
            '{CODE_SOURCE, 1'b0, -1}, '{CODE_WALL, 1'b0, -1},
            '{CODE_WALL,   1'b0, -1}, '{CODE_DEST, 1'b0, -1},
            '{CODE_DEST,   1'b1, 0},
            // Too few cells: unloaded ones behave as walls.
            '{CODE_OPEN,   1'b0, -1}, '{CODE_SOURCE, 1'b1, 0},
            '{CODE_SOURCE, 1'b0, -1}, '{CODE_OPEN, 1'b0, -1},
            '{CODE_OPEN,   1'b0, -1}, '{CODE_DEST, 1'b1, 1}
        };
        foreach (rows[i])
        begin
            typed_next = rows[i].found;
            send_cell(rows[i].code, rows[i].last);
        end

        // Side 0 acts as 1, side above the maximum acts as the maximum.
        write_side(5'd0);
        send_cell(CODE_SOURCE, 1'b0);
        send_cell(CODE_DEST, 1'b1);
        write_side(5'd31);
        for (int i = 0; i < 256; i++)
            send_cell((i == 0) ? CODE_SOURCE : (i == 255) ? CODE_DEST : CODE_OPEN, i == 255);

        // Random part: mostly small sides, now and then any side up to 31.
        items = 0;
        while (items < 1000)
        begin
            if (items > 850) quiet_mode = 1'b1;
            write_side(5'($urandom_range(0, 9) == 0 ? $urandom_range(0, 31)
                                                    : $urandom_range(1, 6)));
            repeat ($urandom_range(2, 6))
            begin
                side = side_now();
                case ($urandom_range(0, 9))
                    0: n = $urandom_range(1, side * side);
                    1: n = side * side + $urandom_range(1, 4);
                    default: n = side * side;
                endcase
                send_grid(n, $urandom_range(0, 40));
                items += n;
            end
        end

        cells_ch.valid <= 1'b0;
        while (expected_found_q.size() > 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        done_sending = 1'b1;
        if (mismatches == 0 && expected_found_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
